// ----- rtl/core/mlpsig_pkg.sv -----
// Shared types, constants and the exponent step table of the sigmoid inference unit.
`timescale 1ns / 1ps
package mlpsig_pkg;

   localparam int DATA_W      = 16;
   localparam int SCORE_W     = 13;
   localparam int IDX_W       = 4;
   localparam int REQ_TDATA_W = 48;
   localparam int RSP_TDATA_W = 24;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 16;
   localparam int EXP_Q       = 32;
   localparam int EXP_STEPS   = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_LAYER_COUNT = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WIDTH0      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WIDTH1      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_WIDTH2      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_WIDTH3      = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_BIAS0       = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_BIAS1       = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_BIAS2       = 3'd7;

   localparam logic FUNC_WEIGHT = 1'b0;
   localparam logic FUNC_SAMPLE = 1'b1;

   // exp(-2^i / 4096) as an unsigned Q0.32 fraction
   function automatic logic [EXP_Q-1:0] exp_step(input int bit_idx);
      real v;
      int  hi;
      int  lo;
      v  = $exp(-(2.0 ** bit_idx) / 4096.0);
      hi = $rtoi(v * 65536.0);
      lo = $rtoi((v * 65536.0 - real'(hi)) * 65536.0);
      return {hi[15:0], lo[15:0]};
   endfunction

   localparam logic [EXP_Q-1:0] EXP_TAB [EXP_STEPS] = '{
      exp_step(0),  exp_step(1),  exp_step(2),  exp_step(3),
      exp_step(4),  exp_step(5),  exp_step(6),  exp_step(7),
      exp_step(8),  exp_step(9),  exp_step(10), exp_step(11),
      exp_step(12), exp_step(13), exp_step(14), exp_step(15)
   };

   typedef struct packed {
      logic act_we;
      logic act_from_sig;
      logic act_re;
      logic act_clear;
      logic wt_we;
      logic wt_re;
      logic mac_valid;
      logic mac_first;
      logic mac_last;
      logic sig_start;
      logic out_load;
      logic out_last;
   } dp_cmd_type;

   typedef struct packed {
      logic mac_done;
      logic sig_done;
      logic out_free;
   } dp_sts_type;

endpackage

// ----- rtl/core/mlpsig_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module mlpsig_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 32
) (
   input  logic                                   clock,
   input  logic                                   we,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                       wdata,
   input  logic                                   re,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                       rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;
endmodule

// ----- rtl/core/mlpsig_sigmoid.sv -----
// Sequential sigmoid unit: exponent by bit-wise constant products, then restoring division.
`timescale 1ns / 1ps
module mlpsig_sigmoid (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic signed [mlpsig_pkg::DATA_W-1:0] x_in,
   output logic                                done,
   output logic [mlpsig_pkg::SCORE_W-1:0]      score
);
   import mlpsig_pkg::*;

   typedef enum logic [4:0] {
      SG_IDLE = 5'b00001,
      SG_EXP  = 5'b00010,
      SG_PREP = 5'b00100,
      SG_DIV  = 5'b01000,
      SG_RND  = 5'b10000
   } sig_state_type;

   sig_state_type        state_ff, state_in;
   logic [EXP_Q:0]       e_ff, e_in;          // Q1.32
   logic [DATA_W-1:0]    mag_ff, mag_in;
   logic                 neg_ff, neg_in;
   logic [3:0]           cnt_ff, cnt_in;
   logic [EXP_Q+1:0]     r_ff, r_in;
   logic [EXP_Q+1:0]     d_ff, d_in;
   logic [SCORE_W-1:0]   q_ff, q_in;
   logic                 done_ff, done_in;

   logic [2*EXP_Q:0]     prod;
   logic [DATA_W:0]      x_ext;
   logic [DATA_W:0]      x_mag;
   logic [EXP_Q+2:0]     r_dbl;
   logic [EXP_Q+2:0]     r_diff;
   logic                 r_ge;

   assign prod   = e_ff * EXP_TAB[cnt_ff];
   assign x_ext  = {x_in[DATA_W-1], x_in};
   assign x_mag  = x_in[DATA_W-1] ? (~x_ext + 1'b1) : x_ext;
   assign r_dbl  = {r_ff, 1'b0};
   assign r_ge   = r_dbl >= {1'b0, d_ff};
   assign r_diff = r_dbl - {1'b0, d_ff};

   always_comb begin
      state_in = state_ff;
      e_in     = e_ff;
      mag_in   = mag_ff;
      neg_in   = neg_ff;
      cnt_in   = cnt_ff;
      r_in     = r_ff;
      d_in     = d_ff;
      q_in     = q_ff;
      done_in  = 1'b0;
      case (state_ff)
         SG_IDLE: begin
            if (start) begin
               mag_in   = x_mag[DATA_W-1:0];
               neg_in   = x_in[DATA_W-1];
               e_in     = {1'b1, {EXP_Q{1'b0}}};
               cnt_in   = '0;
               state_in = SG_EXP;
            end
         end
         SG_EXP: begin
            if (mag_ff[cnt_ff]) begin
               e_in = prod[2*EXP_Q:EXP_Q];
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == 4'(EXP_STEPS - 1)) begin
               state_in = SG_PREP;
            end
         end
         SG_PREP: begin
            d_in     = {2'b01, {EXP_Q{1'b0}}} + {1'b0, e_ff};
            r_in     = neg_ff ? {1'b0, e_ff} : {2'b01, {EXP_Q{1'b0}}};
            q_in     = '0;
            cnt_in   = '0;
            state_in = SG_DIV;
         end
         SG_DIV: begin
            r_in   = r_ge ? r_diff[EXP_Q+1:0] : r_dbl[EXP_Q+1:0];
            q_in   = {q_ff[SCORE_W-2:0], r_ge};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == 4'(SCORE_W - 2)) begin
               state_in = SG_RND;
            end
         end
         SG_RND: begin
            // round half up on the remainder
            if (r_ge) begin
               q_in = q_ff + 1'b1;
            end
            done_in  = 1'b1;
            state_in = SG_IDLE;
         end
         default: begin
            state_in = SG_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SG_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      e_ff   <= e_in;
      mag_ff <= mag_in;
      neg_ff <= neg_in;
      cnt_ff <= cnt_in;
      r_ff   <= r_in;
      d_ff   <= d_in;
      q_ff   <= q_in;
   end

   assign done  = done_ff;
   assign score = q_ff;
endmodule

// ----- rtl/core/mlpsig_dpath.sv -----
// Datapath: weight and activation memories, MAC pipeline, sigmoid unit, result register.
`timescale 1ns / 1ps
module mlpsig_dpath #(
   parameter int MAX_WIDTH  = 16,
   parameter int MAX_LAYERS = 4
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  mlpsig_pkg::dp_cmd_type                cmd,
   output mlpsig_pkg::dp_sts_type                sts,
   input  logic [$clog2(2*MAX_WIDTH)-1:0]        act_waddr,
   input  logic [$clog2(2*MAX_WIDTH)-1:0]        act_raddr,
   input  logic [$clog2((MAX_LAYERS-1)*MAX_WIDTH*MAX_WIDTH)-1:0] wt_waddr,
   input  logic [$clog2((MAX_LAYERS-1)*MAX_WIDTH*MAX_WIDTH)-1:0] wt_raddr,
   input  logic [mlpsig_pkg::DATA_W-1:0]         sample_in,
   input  logic [mlpsig_pkg::DATA_W-1:0]         weight_in,
   input  logic [mlpsig_pkg::DATA_W-1:0]         bias_in,
   input  logic [mlpsig_pkg::IDX_W-1:0]          out_index_in,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [mlpsig_pkg::SCORE_W-1:0]        rsp_score,
   output logic [mlpsig_pkg::IDX_W-1:0]          rsp_index,
   output logic                                  rsp_last
);
   import mlpsig_pkg::*;

   localparam int ACT_DEPTH = 2 * MAX_WIDTH;
   localparam int WT_DEPTH  = (MAX_LAYERS - 1) * MAX_WIDTH * MAX_WIDTH;
   localparam int ACC_W     = 2 * DATA_W + $clog2(MAX_WIDTH) + 1;
   localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(32767);
   localparam logic signed [ACC_W-1:0] SAT_LO = ~SAT_HI;

   logic [ACT_DEPTH-1:0]       act_vld_ff;
   logic                       rd_vld_ff;
   logic [DATA_W-1:0]          act_rdata;
   logic [DATA_W-1:0]          wt_rdata;
   logic [DATA_W-1:0]          act_wdata;
   logic [DATA_W-1:0]          act_val;

   logic                       p1_vld_ff, p1_first_ff, p1_last_ff;
   logic                       p2_vld_ff, p2_first_ff, p2_last_ff;
   logic signed [2*DATA_W-1:0] prod_ff, prod_in;
   logic signed [ACC_W-1:0]    acc_ff, acc_base, acc_in;
   logic                       mac_done_ff;

   logic signed [ACC_W-1:0]    rnd_sum;
   logic signed [ACC_W-1:0]    rnd_sh;
   logic signed [DATA_W-1:0]   sig_x;
   logic                       sig_done;
   logic [SCORE_W-1:0]         sig_score;

   logic                       out_vld_ff;
   logic [SCORE_W-1:0]         out_score_ff;
   logic [IDX_W-1:0]           out_index_ff;
   logic                       out_last_ff;

   assign act_wdata = cmd.act_from_sig ? DATA_W'(sig_score) : sample_in;

   mlpsig_ram #(.WIDTH(DATA_W), .DEPTH(ACT_DEPTH)) u_act_ram (
      .clock (clock),
      .we    (cmd.act_we),
      .waddr (act_waddr),
      .wdata (act_wdata),
      .re    (cmd.act_re),
      .raddr (act_raddr),
      .rdata (act_rdata)
   );

   mlpsig_ram #(.WIDTH(DATA_W), .DEPTH(WT_DEPTH)) u_wt_ram (
      .clock (clock),
      .we    (cmd.wt_we),
      .waddr (wt_waddr),
      .wdata (weight_in),
      .re    (cmd.wt_re),
      .raddr (wt_raddr),
      .rdata (wt_rdata)
   );

   // an entry never written in this run reads as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         act_vld_ff <= '0;
      end else if (cmd.act_clear) begin
         act_vld_ff <= '0;
      end else if (cmd.act_we) begin
         act_vld_ff[act_waddr] <= 1'b1;
      end
      if (cmd.act_re) begin
         rd_vld_ff <= act_vld_ff[act_raddr];
      end
   end

   assign act_val = rd_vld_ff ? act_rdata : '0;

   assign prod_in  = $signed(act_val) * $signed(wt_rdata);
   assign acc_base = p2_first_ff ?
                     {{(ACC_W-DATA_W-12){bias_in[DATA_W-1]}}, bias_in, 12'd0} : acc_ff;
   assign acc_in   = acc_base + {{(ACC_W-2*DATA_W){prod_ff[2*DATA_W-1]}}, prod_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_vld_ff   <= 1'b0;
         p2_vld_ff   <= 1'b0;
         mac_done_ff <= 1'b0;
      end else begin
         p1_vld_ff   <= cmd.mac_valid;
         p2_vld_ff   <= p1_vld_ff;
         mac_done_ff <= p2_vld_ff & p2_last_ff;
      end
      p1_first_ff <= cmd.mac_first;
      p1_last_ff  <= cmd.mac_last;
      p2_first_ff <= p1_first_ff;
      p2_last_ff  <= p1_last_ff;
      prod_ff     <= prod_in;
      if (p2_vld_ff) begin
         acc_ff <= acc_in;
      end
   end

   // round to Q4.12 and saturate to 16 bits
   assign rnd_sum = acc_ff + $signed({{(ACC_W-12){1'b0}}, 12'd2048});
   assign rnd_sh  = rnd_sum >>> 12;

   always_comb begin
      if (rnd_sh > SAT_HI) begin
         sig_x = SAT_HI[DATA_W-1:0];
      end else if (rnd_sh < SAT_LO) begin
         sig_x = SAT_LO[DATA_W-1:0];
      end else begin
         sig_x = rnd_sh[DATA_W-1:0];
      end
   end

   mlpsig_sigmoid u_sigmoid (
      .clock (clock),
      .reset (reset),
      .start (cmd.sig_start),
      .x_in  (sig_x),
      .done  (sig_done),
      .score (sig_score)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (cmd.out_load) begin
         out_vld_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_vld_ff <= 1'b0;
      end
      if (cmd.out_load) begin
         out_score_ff <= act_val[SCORE_W-1:0];
         out_index_ff <= out_index_in;
         out_last_ff  <= cmd.out_last;
      end
   end

   assign sts.mac_done = mac_done_ff;
   assign sts.sig_done = sig_done;
   assign sts.out_free = ~out_vld_ff | rsp_ready;

   assign rsp_valid = out_vld_ff;
   assign rsp_score = out_score_ff;
   assign rsp_index = out_index_ff;
   assign rsp_last  = out_last_ff;
endmodule

// ----- rtl/core/mlpsig_ctrl.sv -----
// Controller: configuration registers, request intake and the layer/neuron/term sequencer.
`timescale 1ns / 1ps
module mlpsig_ctrl #(
   parameter int MAX_WIDTH  = 16,
   parameter int MAX_LAYERS = 4
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic                                  func,
   input  logic [1:0]                            source_layer,
   input  logic [3:0]                            source_unit,
   input  logic [3:0]                            dest_unit,
   input  logic                                  last_sample,
   input  logic                                  csr_we,
   input  logic [mlpsig_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [mlpsig_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  mlpsig_pkg::dp_sts_type                sts,
   output mlpsig_pkg::dp_cmd_type                cmd,
   output logic [$clog2(2*MAX_WIDTH)-1:0]        act_waddr,
   output logic [$clog2(2*MAX_WIDTH)-1:0]        act_raddr,
   output logic [$clog2((MAX_LAYERS-1)*MAX_WIDTH*MAX_WIDTH)-1:0] wt_waddr,
   output logic [$clog2((MAX_LAYERS-1)*MAX_WIDTH*MAX_WIDTH)-1:0] wt_raddr,
   output logic [mlpsig_pkg::DATA_W-1:0]         bias_out,
   output logic [mlpsig_pkg::IDX_W-1:0]          out_index
);
   import mlpsig_pkg::*;

   localparam int AAW    = $clog2(2 * MAX_WIDTH);
   localparam int WAW    = $clog2((MAX_LAYERS - 1) * MAX_WIDTH * MAX_WIDTH);
   localparam int IW     = $clog2(MAX_WIDTH);
   localparam int CW     = $clog2(MAX_WIDTH + 1);
   localparam int L_TOP  = (MAX_LAYERS < 4) ? MAX_LAYERS : 4;

   typedef enum logic [6:0] {
      S_IDLE    = 7'b0000001,
      S_LOAD    = 7'b0000010,
      S_DRAIN   = 7'b0000100,
      S_SIG     = 7'b0001000,
      S_STORE   = 7'b0010000,
      S_EMIT_RD = 7'b0100000,
      S_EMIT_LD = 7'b1000000
   } ctrl_state_type;

   function automatic logic [CW-1:0] eff_w(input logic [4:0] w);
      if (w == 5'd0) begin
         return CW'(1);
      end else if (int'(w) > MAX_WIDTH) begin
         return CW'(MAX_WIDTH);
      end
      return CW'(w);
   endfunction

   ctrl_state_type    state_ff, state_in;
   logic [2:0]        layer_count_ff;
   logic [4:0]        width_ff [4];
   logic [DATA_W-1:0] bias_ff [3];
   logic [CW-1:0]     count_ff, count_in;
   logic [1:0]        layer_ff, layer_in;
   logic [IW-1:0]     j_ff, j_in;
   logic [IW-1:0]     k_ff, k_in;

   logic [2:0]        layers_eff;
   logic [1:0]        layer_top;
   logic [CW-1:0]     w0, wprev, wcur, wlast;
   logic              k_last, j_last, e_last;
   logic              accept;
   logic              wt_addr_ok;
   logic [AAW-1:0]    cur_base, nxt_base, out_base;

   always_comb begin
      if (layer_count_ff < 3'd2) begin
         layers_eff = 3'd2;
      end else if (int'(layer_count_ff) > L_TOP) begin
         layers_eff = 3'(L_TOP);
      end else begin
         layers_eff = layer_count_ff;
      end
   end

   assign layer_top = 2'(layers_eff - 3'd1);
   assign w0        = eff_w(width_ff[0]);
   assign wprev     = eff_w(width_ff[layer_ff - 2'd1]);
   assign wcur      = eff_w(width_ff[layer_ff]);
   assign wlast     = eff_w(width_ff[layer_top]);
   assign k_last    = (CW'(k_ff) + CW'(1)) == wprev;
   assign j_last    = (CW'(j_ff) + CW'(1)) == wcur;
   assign e_last    = (CW'(j_ff) + CW'(1)) == wlast;
   assign accept    = req_valid & req_ready;
   assign wt_addr_ok = (int'(source_layer) <= MAX_LAYERS - 2) &&
                       (int'(source_unit) < MAX_WIDTH) && (int'(dest_unit) < MAX_WIDTH);

   // the two activation banks alternate from layer to layer
   assign cur_base = (layer_ff[0] == 1'b1) ? '0 : AAW'(MAX_WIDTH);
   assign nxt_base = (layer_ff[0] == 1'b1) ? AAW'(MAX_WIDTH) : '0;
   assign out_base = (layer_top[0] == 1'b1) ? AAW'(MAX_WIDTH) : '0;

   assign wt_waddr  = WAW'((int'(source_layer) * MAX_WIDTH + int'(source_unit)) * MAX_WIDTH
                           + int'(dest_unit));
   assign wt_raddr  = WAW'((int'(layer_ff - 2'd1) * MAX_WIDTH + int'(k_ff)) * MAX_WIDTH
                           + int'(j_ff));
   assign act_waddr = (state_ff == S_IDLE) ? AAW'(count_ff) : nxt_base + AAW'(j_ff);
   assign act_raddr = (state_ff == S_LOAD) ? cur_base + AAW'(k_ff) : out_base + AAW'(j_ff);
   assign bias_out  = bias_ff[layer_ff - 2'd1];
   assign out_index = IDX_W'(j_ff);
   assign req_ready = (state_ff == S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         layer_count_ff <= 3'd2;
         width_ff[0]    <= 5'd16;
         width_ff[1]    <= 5'd16;
         width_ff[2]    <= 5'd16;
         width_ff[3]    <= 5'd16;
         bias_ff[0]     <= '0;
         bias_ff[1]     <= '0;
         bias_ff[2]     <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_LAYER_COUNT: layer_count_ff <= csr_wdata[2:0];
            CSR_WIDTH0:      width_ff[0]    <= csr_wdata[4:0];
            CSR_WIDTH1:      width_ff[1]    <= csr_wdata[4:0];
            CSR_WIDTH2:      width_ff[2]    <= csr_wdata[4:0];
            CSR_WIDTH3:      width_ff[3]    <= csr_wdata[4:0];
            CSR_BIAS0:       bias_ff[0]     <= csr_wdata;
            CSR_BIAS1:       bias_ff[1]     <= csr_wdata;
            CSR_BIAS2:       bias_ff[2]     <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      layer_in = layer_ff;
      j_in     = j_ff;
      k_in     = k_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (func == FUNC_WEIGHT) begin
                  cmd.wt_we = wt_addr_ok;
               end else begin
                  if (count_ff < w0) begin
                     cmd.act_we = 1'b1;
                     count_in   = count_ff + 1'b1;
                  end
                  if (last_sample) begin
                     layer_in = 2'd1;
                     j_in     = '0;
                     k_in     = '0;
                     state_in = S_LOAD;
                  end
               end
            end
         end
         S_LOAD: begin
            cmd.act_re    = 1'b1;
            cmd.wt_re     = 1'b1;
            cmd.mac_valid = 1'b1;
            cmd.mac_first = (k_ff == '0);
            cmd.mac_last  = k_last;
            k_in          = k_ff + 1'b1;
            if (k_last) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            if (sts.mac_done) begin
               cmd.sig_start = 1'b1;
               state_in      = S_SIG;
            end
         end
         S_SIG: begin
            if (sts.sig_done) begin
               state_in = S_STORE;
            end
         end
         S_STORE: begin
            cmd.act_we       = 1'b1;
            cmd.act_from_sig = 1'b1;
            k_in             = '0;
            if (j_last) begin
               j_in = '0;
               if (layer_ff == layer_top) begin
                  state_in = S_EMIT_RD;
               end else begin
                  layer_in = layer_ff + 1'b1;
                  state_in = S_LOAD;
               end
            end else begin
               j_in     = j_ff + 1'b1;
               state_in = S_LOAD;
            end
         end
         S_EMIT_RD: begin
            cmd.act_re = 1'b1;
            state_in   = S_EMIT_LD;
         end
         S_EMIT_LD: begin
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_last = e_last;
               if (e_last) begin
                  cmd.act_clear = 1'b1;
                  count_in      = '0;
                  state_in      = S_IDLE;
               end else begin
                  j_in     = j_ff + 1'b1;
                  state_in = S_EMIT_RD;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
      layer_ff <= layer_in;
      j_ff     <= j_in;
      k_ff     <= k_in;
   end

`ifndef NO_ASSERTIONS
   a_store_after_sig: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_STORE) |-> $past(sts.sig_done))
      else $error("activation store without a finished sigmoid");
   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> sts.out_free)
      else $error("result register overwritten while occupied");
   a_idle_after_clear: assert property (@(posedge clock) disable iff (reset)
      $rose(state_ff == S_IDLE) |-> $past(cmd.act_clear))
      else $error("run ended without clearing the activation buffer");
`endif
endmodule

// ----- rtl/core/mlp_sigmoid_inference_unit.sv -----
// Top level of the multilayer perceptron sigmoid inference unit.
`timescale 1ns / 1ps
// Usage:
//   req_* carries requests. req_tuser = 0 loads one weight into the weight
//   memory, req_tuser = 1 appends one Q4.12 input activation; req_tlast on an
//   activation request starts inference over the configured layers.
//   rsp_* delivers one Q1.12 sigmoid score per output neuron, in index order,
//   with rsp_tlast on the last neuron of the run.
//   csr_* writes layer count, layer widths and per-layer biases; write only
//   while the unit is idle.
// Sequencing:
//   Weight and plain activation requests are taken one per cycle while idle.
//   An inference runs one shared multiply-accumulate pipeline and one
//   sequential sigmoid unit; each neuron takes one product term per cycle,
//   the MAC drain, 16 exponent steps, one divider setup, 12 division steps,
//   one rounding step, the hand-back of the score and one store. Results
//   then leave one at a time through the result register, each read from
//   the activation buffer first. req_tready is low for the whole inference.
// Reset: synchronous, clears control, configuration to defaults and the
//   activation buffer; weight memory is undefined until written.
// Back-pressure: a low rsp_tready holds the result register and stalls the
//   output sequencer; new requests are taken once the final score is loaded.
module mlp_sigmoid_inference_unit #(
   parameter int MAX_WIDTH  = 16,
   parameter int MAX_LAYERS = 4
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   // [1:0] source_layer, [5:2] source_unit, [9:6] dest_unit,
   // [25:10] weight_value, [41:26] sample_value, [47:42] zero
   input  logic [mlpsig_pkg::REQ_TDATA_W-1:0]     req_tdata,
   // [0] func
   input  logic                                   req_tuser,
   input  logic                                   req_tlast,
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   // [12:0] class_score, [16:13] output_index, [23:17] zero
   output logic [mlpsig_pkg::RSP_TDATA_W-1:0]     rsp_tdata,
   output logic                                   rsp_tlast,
   input  logic                                   csr_we,
   input  logic [mlpsig_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [mlpsig_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import mlpsig_pkg::*;

   localparam int AAW = $clog2(2 * MAX_WIDTH);
   localparam int WAW = $clog2((MAX_LAYERS - 1) * MAX_WIDTH * MAX_WIDTH);

   dp_cmd_type         cmd;
   dp_sts_type         sts;
   logic [AAW-1:0]     act_waddr, act_raddr;
   logic [WAW-1:0]     wt_waddr, wt_raddr;
   logic [DATA_W-1:0]  bias;
   logic [IDX_W-1:0]   out_index;
   logic [SCORE_W-1:0] rsp_score;
   logic [IDX_W-1:0]   rsp_index;

   // unpack the request fields
   mlpsig_ctrl #(.MAX_WIDTH(MAX_WIDTH), .MAX_LAYERS(MAX_LAYERS)) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_tvalid),
      .req_ready    (req_tready),
      .func         (req_tuser),
      .source_layer (req_tdata[1:0]),
      .source_unit  (req_tdata[5:2]),
      .dest_unit    (req_tdata[9:6]),
      .last_sample  (req_tlast),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .sts          (sts),
      .cmd          (cmd),
      .act_waddr    (act_waddr),
      .act_raddr    (act_raddr),
      .wt_waddr     (wt_waddr),
      .wt_raddr     (wt_raddr),
      .bias_out     (bias),
      .out_index    (out_index)
   );

   mlpsig_dpath #(.MAX_WIDTH(MAX_WIDTH), .MAX_LAYERS(MAX_LAYERS)) u_dpath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .sts          (sts),
      .act_waddr    (act_waddr),
      .act_raddr    (act_raddr),
      .wt_waddr     (wt_waddr),
      .wt_raddr     (wt_raddr),
      .sample_in    (req_tdata[41:26]),
      .weight_in    (req_tdata[25:10]),
      .bias_in      (bias),
      .out_index_in (out_index),
      .rsp_valid    (rsp_tvalid),
      .rsp_ready    (rsp_tready),
      .rsp_score    (rsp_score),
      .rsp_index    (rsp_index),
      .rsp_last     (rsp_tlast)
   );

   // pack the result fields, zero fill to whole bytes
   assign rsp_tdata = {{(RSP_TDATA_W-SCORE_W-IDX_W){1'b0}}, rsp_index, rsp_score};
endmodule
